// ----- rtl/mpv_pkg.sv -----
// Package for the message PDU validator.
// Holds the widths, the header layout constants and the result struct.
// No dependencies; used by mpv_byte_check and message_pdu_validator.
package mpv_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned LenW        = 16;
  localparam int unsigned PosW        = 17;
  localparam int unsigned HeaderBytes = 12;

  localparam logic [PosW-1:0]  POS_MAX        = {PosW{1'b1}};
  localparam logic [ByteW-1:0] SUM_ALL_ONES   = 8'hFF;
  localparam logic [ByteW-1:0] OPCODE_DEFAULT = 8'd10;

  // Fixed header positions
  localparam logic [PosW-1:0] POS_OPCODE  = 17'd0;
  localparam logic [PosW-1:0] POS_ZERO_A  = 17'd1;
  localparam logic [PosW-1:0] POS_ZERO_B  = 17'd2;
  localparam logic [PosW-1:0] POS_LEN_HI  = 17'd4;
  localparam logic [PosW-1:0] POS_LEN_LO  = 17'd5;
  localparam logic [PosW-1:0] POS_PAD_LO  = 17'd6;
  localparam logic [PosW-1:0] POS_TEXT    = 17'd12;

  typedef struct packed {
    logic            fire;
    logic            pdu_valid;
    logic [LenW-1:0] text_length;
  } mpv_result_t;

endpackage

// ----- rtl/message_pdu_validator.sv -----
// Top level of the message PDU validator: input register, byte check and result register.
// Depends on mpv_pkg and mpv_byte_check.
//
//  channel | ports                                   | payload
//  in      | in_tvalid  in_tready  in_tdata in_tlast | data_byte, is_last
//  out     | out_tvalid out_tready out_tdata out_tuser| text_length, pdu_valid
//  cfg     | cfg_valid  cfg_ready  cfg_data          | message_opcode
//
// One beat per cycle unless the result stalls; a beat waits in the input register, and on the
// last byte of a PDU its result is in the result register in the cycle after the beat leaves.
// Reset (rst_n low, synchronous) clears all control state and sets the opcode to 10.
// A stalled result holds the input register; the input side keeps moving while the result
// register is empty or is being taken. cfg_ready is always high.
module message_pdu_validator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] data_byte
  input  logic                       in_tlast,   // is_last
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [15:0]                out_tdata,  // [15:0] text_length
  output logic                       out_tuser,  // [0] pdu_valid
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [7:0]                 cfg_data    // [7:0] message_opcode
);

  logic                        in_vld_r;
  logic [mpv_pkg::ByteW-1:0]   in_byte_r;
  logic                        in_last_r;
  logic                        out_vld_r;
  logic [mpv_pkg::LenW-1:0]    out_len_r;
  logic                        out_ok_r;
  logic [mpv_pkg::ByteW-1:0]   opcode_r;
  logic                        adv;
  mpv_pkg::mpv_result_t        res;

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opcode_r <= mpv_pkg::OPCODE_DEFAULT;
    end else if (cfg_valid) begin
      opcode_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  mpv_byte_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .data_byte (in_byte_r),
    .is_last   (in_last_r),
    .opcode    (opcode_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res.fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.fire) begin
      out_len_r <= res.text_length;
      out_ok_r  <= res.pdu_valid;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_len_r;
  assign out_tuser  = out_ok_r;

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && !out_tready |-> !in_tready)
    else $error("input register released while result stalled");

  a_no_result_mid_pdu: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !in_last_r && !out_vld_r |=> !out_vld_r)
    else $error("result produced for a byte that is not last");

  a_result_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_last_r |=> out_vld_r)
    else $error("last byte gave no result");

endmodule

// ----- rtl/mpv_byte_check.sv -----
// Per-byte check and running state of the message PDU validator.
// Holds position, length, checksum and validity; depends on mpv_pkg.
// Produces the result of the beat being processed combinationally.
module mpv_byte_check (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic [mpv_pkg::ByteW-1:0]  data_byte,
  input  logic                       is_last,
  input  logic [mpv_pkg::ByteW-1:0]  opcode,
  output mpv_pkg::mpv_result_t       res
);

  logic [mpv_pkg::PosW-1:0]  pos_r,   pos_nxt;
  logic [mpv_pkg::LenW-1:0]  len_r,   len_nxt;
  logic [mpv_pkg::ByteW-1:0] sum_r,   sum_nxt;
  logic                      ok_r,    ok_nxt;

  logic [mpv_pkg::PosW-1:0]  text_end;
  logic [mpv_pkg::PosW:0]    text_end_fin;
  logic [mpv_pkg::PosW:0]    pos_inc;
  logic [mpv_pkg::ByteW:0]   sum_wide;
  logic [mpv_pkg::ByteW-1:0] sum_fold;
  logic                      byte_zero;
  logic                      pos_len_seen;

  assign byte_zero = (data_byte == '0);
  assign text_end  = mpv_pkg::POS_TEXT + {1'b0, len_r};
  assign sum_wide  = {1'b0, sum_r} + {1'b0, data_byte};
  // End-around carry
  assign sum_fold  = sum_wide[mpv_pkg::ByteW-1:0] +
                     {{(mpv_pkg::ByteW-1){1'b0}}, sum_wide[mpv_pkg::ByteW]};
  assign pos_inc   = {1'b0, pos_r} + 18'd1;
  assign pos_len_seen = (pos_r >= mpv_pkg::POS_LEN_LO);

  always_comb begin
    len_nxt = len_r;
    ok_nxt  = ok_r;
    if (pos_r == mpv_pkg::POS_OPCODE) begin
      if (data_byte != opcode) ok_nxt = 1'b0;
    end else if (pos_r == mpv_pkg::POS_ZERO_A || pos_r == mpv_pkg::POS_ZERO_B ||
                 (pos_r >= mpv_pkg::POS_PAD_LO && pos_r < mpv_pkg::POS_TEXT)) begin
      if (!byte_zero) ok_nxt = 1'b0;
    end else if (pos_r == mpv_pkg::POS_LEN_HI) begin
      len_nxt = {data_byte, 8'h00};
    end else if (pos_r == mpv_pkg::POS_LEN_LO) begin
      len_nxt = {len_r[mpv_pkg::LenW-1:mpv_pkg::ByteW], data_byte};
    end else if (pos_r >= mpv_pkg::POS_TEXT) begin
      // Inside the text every byte is nonzero, after it every byte is zero.
      if ((pos_r < text_end) == byte_zero) ok_nxt = 1'b0;
    end
    sum_nxt = sum_fold;
    if (pos_r != mpv_pkg::POS_MAX) pos_nxt = pos_inc[mpv_pkg::PosW-1:0];
    else                           pos_nxt = pos_r;
  end

  assign text_end_fin = {1'b0, mpv_pkg::POS_TEXT} + {2'b00, len_nxt};

  always_comb begin
    res.fire        = adv && is_last;
    res.pdu_valid   = ok_nxt && (sum_nxt == mpv_pkg::SUM_ALL_ONES) && pos_len_seen &&
                      (pos_inc >= text_end_fin);
    res.text_length = pos_len_seen ? len_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (adv && is_last)) begin
      pos_r <= '0;
      len_r <= '0;
      sum_r <= '0;
      ok_r  <= 1'b1;
    end else if (adv) begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
      sum_r <= sum_nxt;
      ok_r  <= ok_nxt;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    adv && is_last |=> pos_r == '0 && sum_r == '0 && ok_r)
    else $error("state not cleared after last beat");

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !is_last && pos_r == mpv_pkg::POS_MAX |=> pos_r == mpv_pkg::POS_MAX)
    else $error("byte position wrapped");

  a_valid_needs_length: assert property (@(posedge clk) disable iff (!rst_n)
    res.fire && res.pdu_valid |-> pos_r >= mpv_pkg::POS_LEN_LO)
    else $error("PDU reported valid before its length bytes");

endmodule
